>>> hw/rtl/mfpp_pkg.sv
// ----------------------------------------------------------------------------
// mfpp_pkg: shared types and constants for the frame buffer pixel plotter
// Mode codes, default screen size and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mfpp_pkg;

	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 240;

	localparam logic [1:0] MODE_PLOT  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture request, issue memory read
		logic finish;      // complete plot / read / reject
		logic sweep;       // write the entry at the sweep counter
		logic sweep_dirty; // dirty value written by the sweep
		logic clear_done;  // post clear result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;  // sweep counter at last entry
	} status_t;

endpackage

>>> hw/rtl/mono_framebuffer_pixel_plot.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_plot: 1-bpp frame buffer with per-byte dirty map
// Requests: raise start with mode and operands; the request is taken at a
// rising edge where start is high and busy is low. Modes: plot pixel, clear
// buffer, read byte; mode three and out-of-range operands are rejected.
// Results: buffer_byte, byte_dirty, any_change and rejected are valid for one
// cycle while done is high. The receiver cannot stall, so results are never
// held back and nothing waits on the output side.
// Sequence: plot and read requests read memory at accept, and a plot writes
// the byte back in the finish state; plot, read and rejected requests
// register their result there and then show done. A new request can be
// taken in that done cycle. Clear sweeps all ROW_BYTES*SCREEN_HEIGHT words
// one per cycle (9600 at 320x240); done follows the last write.
// Reset: arst_n starts a clearing pass over all words with busy high; no
// request is taken until it ends.
// ----------------------------------------------------------------------------
module mono_framebuffer_pixel_plot import mfpp_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [10:0] pixel_x,
	input  logic signed [10:0] pixel_y,
	input  logic               pixel_dark,
	input  logic [13:0]        byte_address,
	output logic               done,
	output logic [7:0]         buffer_byte,
	output logic               byte_dirty,
	output logic               any_change,
	output logic               rejected
);

	cmd_t    cmd;
	status_t status;

	// sequencing: init sweep, accept, finish, clear sweep
	mfpp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// memory, address math, result registers
	mfpp_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_dark   (pixel_dark),
		.byte_address (byte_address),
		.done         (done),
		.buffer_byte  (buffer_byte),
		.byte_dirty   (byte_dirty),
		.any_change   (any_change),
		.rejected     (rejected)
	);

endmodule

>>> hw/rtl/mfpp_ctrl.sv
// ----------------------------------------------------------------------------
// mfpp_ctrl: sequencing for the frame buffer pixel plotter
// Runs the power-up clearing pass, accepts requests and steps the datapath
// through plot/read completion or a full clear sweep.
// ----------------------------------------------------------------------------
module mfpp_ctrl import mfpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  status_t    status,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_FINISH,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (status.sweep_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= (mode == MODE_CLEAR) ? ST_CLEAR : ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				ST_CLEAR: begin
					if (status.sweep_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_INIT;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy            = busy_q;
	assign cmd.load        = (state_q == ST_IDLE) && start;
	assign cmd.finish      = (state_q == ST_FINISH);
	assign cmd.sweep       = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign cmd.sweep_dirty = (state_q == ST_CLEAR);
	assign cmd.clear_done  = (state_q == ST_CLEAR) && status.sweep_last;

endmodule

>>> hw/rtl/mfpp_datapath.sv
// ----------------------------------------------------------------------------
// mfpp_datapath: pixel memory, address math and result registers
// One memory word per byte: {dirty, pixels}. Plot is a read at accept and a
// write in the next cycle; clear and power-up walk a counter over all words.
// ----------------------------------------------------------------------------
module mfpp_datapath import mfpp_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [1:0]         mode,
	input  logic signed [10:0] pixel_x,
	input  logic signed [10:0] pixel_y,
	input  logic               pixel_dark,
	input  logic [13:0]        byte_address,
	output logic               done,
	output logic [7:0]         buffer_byte,
	output logic               byte_dirty,
	output logic               any_change,
	output logic               rejected
);

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic [8:0] mem [STORE_BYTES];

	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] addr_q;
	logic [8:0]        rd_q;
	logic [2:0]        bit_q;
	logic              dark_q;
	logic              plot_q;
	logic              reject_q;
	logic              flag_q;

	logic              done_q;
	logic [7:0]        byte_q;
	logic              dirty_q;
	logic              change_q;
	logic              rej_q;

	// request decode
	logic [11:0]       x_u, y_u;
	logic              x_bad, y_bad, rd_bad, req_bad;
	logic [ADDR_W-1:0] plot_addr, req_addr;

	assign x_u    = {2'b00, pixel_x[9:0]};
	assign y_u    = {2'b00, pixel_y[9:0]};
	assign x_bad  = pixel_x[10] || (x_u >= 12'(SCREEN_WIDTH));
	assign y_bad  = pixel_y[10] || (y_u >= 12'(SCREEN_HEIGHT));
	assign rd_bad = (32'(byte_address) >= 32'(STORE_BYTES));

	assign plot_addr = ADDR_W'(ADDR_W'(pixel_y[9:0]) * ADDR_W'(ROW_BYTES))
	                 + ADDR_W'(pixel_x[9:3]);

	always_comb begin
		unique case (mode)
			MODE_PLOT: begin
				req_bad  = x_bad || y_bad;
				req_addr = plot_addr;
			end
			MODE_READ: begin
				req_bad  = rd_bad;
				req_addr = ADDR_W'(byte_address);
			end
			default: begin
				req_bad  = 1'b1;
				req_addr = plot_addr;
			end
		endcase
	end

	// read-modify-write of the plotted byte
	logic [7:0] mask, new_byte;
	logic       bit_changed, new_dirty;

	assign mask        = 8'h80 >> bit_q;
	assign new_byte    = dark_q ? (rd_q[7:0] | mask) : (rd_q[7:0] & ~mask);
	assign bit_changed = (new_byte != rd_q[7:0]);
	assign new_dirty   = rd_q[8] | bit_changed;

	logic              plot_wr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [8:0]        wr_data;

	assign plot_wr = cmd.finish && plot_q && !reject_q;

	always_comb begin
		wr_en   = cmd.sweep || plot_wr;
		wr_addr = cmd.sweep ? cnt_q : addr_q;
		wr_data = cmd.sweep ? {cmd.sweep_dirty, 8'h00} : {new_dirty, new_byte};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load && !req_bad) begin
			rd_q <= mem[req_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q   <= req_addr;
			bit_q    <= pixel_x[2:0];
			dark_q   <= pixel_dark;
			plot_q   <= (mode == MODE_PLOT);
			reject_q <= req_bad;
		end
	end

	assign status.sweep_last = (cnt_q == ADDR_W'(STORE_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			flag_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				cnt_q <= status.sweep_last ? '0 : cnt_q + 1'b1;
			end
			if (plot_wr && bit_changed) begin
				flag_q <= 1'b1;
			end
			done_q <= cmd.finish || cmd.clear_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_done) begin
			byte_q   <= 8'h00;
			dirty_q  <= 1'b1;
			change_q <= flag_q;
			rej_q    <= 1'b0;
		end else if (cmd.finish) begin
			rej_q <= reject_q;
			if (reject_q) begin
				byte_q   <= 8'h00;
				dirty_q  <= 1'b0;
				change_q <= flag_q;
			end else if (plot_q) begin
				byte_q   <= new_byte;
				dirty_q  <= new_dirty;
				change_q <= flag_q | bit_changed;
			end else begin
				byte_q   <= rd_q[7:0];
				dirty_q  <= rd_q[8];
				change_q <= flag_q;
			end
		end
	end

	assign done        = done_q;
	assign buffer_byte = byte_q;
	assign byte_dirty  = dirty_q;
	assign any_change  = change_q;
	assign rejected    = rej_q;

endmodule
